### hw/rtl/lgf_pkg.sv
// Shared types and constants for the long-gap alignment filter.
// Used by lgf_cfg_regs, lgf_core and cigar_long_gap_filter; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lgf_pkg;

  localparam int unsigned GapW   = 28;
  localparam int unsigned DelW   = 31;
  localparam int unsigned RunW   = 28;
  localparam int unsigned PosW   = 31;
  localparam int unsigned CtgW   = 16;
  localparam int unsigned OpW    = 4;
  localparam int unsigned CountW = 32;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  localparam logic [GapW-1:0] MinGapRst      = GapW'(700000);
  localparam logic [DelW-1:0] MaxDeletionRst = DelW'(1500000);
  localparam logic [RunW-1:0] ShortRunRst    = RunW'(15);

  typedef enum logic [1:0] {
    CMD_SPLIT = 2'd0,
    CMD_SUPP  = 2'd1,
    CMD_OP    = 2'd2
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MIN_GAP      = 2'd0,
    REG_MAX_DELETION = 2'd1,
    REG_SHORT_RUN    = 2'd2
  } cfg_reg_e;

  localparam logic [OpW-1:0] OpM   = 4'd0;
  localparam logic [OpW-1:0] OpI   = 4'd1;
  localparam logic [OpW-1:0] OpD   = 4'd2;
  localparam logic [OpW-1:0] OpN   = 4'd3;
  localparam logic [OpW-1:0] OpP   = 4'd6;
  localparam logic [OpW-1:0] OpEq  = 4'd7;
  localparam logic [OpW-1:0] OpX   = 4'd8;

  typedef struct packed {
    logic [1:0]      command;
    logic            already_filtered;
    logic            three_mate;
    logic [CtgW-1:0] contig;
    logic            reverse_strand;
    logic [PosW-1:0] start_pos;
    logic [PosW-1:0] end_pos;
    logic [OpW-1:0]  op_code;
    logic [RunW-1:0] op_len;
    logic            last_op;
    logic            last_of_alignment;
  } item_t;

  typedef struct packed {
    logic [GapW-1:0] min_gap;
    logic [DelW-1:0] max_deletion;
    logic [RunW-1:0] short_run;
  } cfg_t;

  typedef struct packed {
    logic              valid;
    logic              discarded;
    logic              was_filtered;
    logic [CountW-1:0] kept_count;
  } res_t;

endpackage

`default_nettype wire

### hw/rtl/lgf_cfg_regs.sv
// Configuration registers of the long-gap filter: min_gap, max_deletion, short_run.
// Depends on lgf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lgf_cfg_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          wr_en_i,
  input  wire logic [lgf_pkg::CfgIdxW-1:0]   wr_index_i,
  input  wire logic [lgf_pkg::CfgDataW-1:0]  wr_data_i,
  output lgf_pkg::cfg_t                      cfg_o
);

  lgf_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (wr_index_i)
        lgf_pkg::REG_MIN_GAP:      cfg_d.min_gap      = wr_data_i[lgf_pkg::GapW-1:0];
        lgf_pkg::REG_MAX_DELETION: cfg_d.max_deletion = wr_data_i[lgf_pkg::DelW-1:0];
        lgf_pkg::REG_SHORT_RUN:    cfg_d.short_run    = wr_data_i[lgf_pkg::RunW-1:0];
        default:                   cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_gap      <= lgf_pkg::MinGapRst;
      cfg_q.max_deletion <= lgf_pkg::MaxDeletionRst;
      cfg_q.short_run    <= lgf_pkg::ShortRunRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

### hw/rtl/lgf_core.sv
// Per-item update of the long-gap filter: alignment state, run tracking, verdict.
// Depends on lgf_pkg; the result it forms is registered by the top level.
`timescale 1ns / 1ps
`default_nettype none

module lgf_core (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  step_i,
  input  lgf_pkg::item_t item_i,
  input  lgf_pkg::cfg_t  cfg_i,
  output lgf_pkg::res_t  res_o
);

  logic [lgf_pkg::CtgW-1:0]   split_contig_q, split_contig_d;
  logic                       split_reverse_q, split_reverse_d;
  logic [lgf_pkg::PosW-1:0]   split_start_q, split_start_d;
  logic [lgf_pkg::PosW-1:0]   split_end_q, split_end_d;
  logic                       is_split_q, is_split_d;
  logic                       skip_q, skip_d;
  logic                       del_in_range_q, del_in_range_d;
  logic [lgf_pkg::RunW-1:0]   run_q, run_d;
  logic                       pending_q, pending_d;
  logic                       first_q, first_d;
  logic                       hit_q, hit_d;
  logic [lgf_pkg::CountW-1:0] kept_q, kept_d;

  logic                       same_side;
  logic [lgf_pkg::PosW:0]     del_diff;
  logic                       del_ok;
  logic [lgf_pkg::RunW:0]     run_sum;
  logic [lgf_pkg::RunW-1:0]   run_add;
  logic                       end_mate;
  logic                       left_short;
  logic                       is_match;
  logic                       is_indel;
  logic [lgf_pkg::RunW-1:0]   run_mid;
  logic                       pending_mid;
  logic                       hit_mid;
  logic                       hit_end;

  // Deletion between split read and supplementary mate.
  always_comb begin
    same_side = is_split_q && (item_i.contig == split_contig_q) &&
                (item_i.reverse_strand == split_reverse_q);
    if (!same_side) begin
      del_diff = '0;
    end else if (item_i.reverse_strand) begin
      del_diff = {1'b0, item_i.start_pos} - {1'b0, split_end_q};
    end else begin
      del_diff = {1'b0, split_start_q} - {1'b0, item_i.end_pos};
    end
    del_ok = !del_diff[lgf_pkg::PosW] &&
             (del_diff[lgf_pkg::PosW-1:0] >= {3'b000, cfg_i.min_gap}) &&
             (del_diff[lgf_pkg::PosW-1:0] <= cfg_i.max_deletion);
  end

  always_comb begin
    run_sum  = {1'b0, run_q} + {1'b0, item_i.op_len};
    run_add  = run_sum[lgf_pkg::RunW] ? '1 : run_sum[lgf_pkg::RunW-1:0];
    end_mate = item_i.last_op || item_i.last_of_alignment;
    left_short = run_q <= cfg_i.short_run;
    is_match = (item_i.op_code == lgf_pkg::OpM) || (item_i.op_code == lgf_pkg::OpEq) ||
               (item_i.op_code == lgf_pkg::OpX);
    is_indel = (item_i.op_code == lgf_pkg::OpI) || (item_i.op_code == lgf_pkg::OpD) ||
               (item_i.op_code == lgf_pkg::OpP);

    // Operation itself.
    if (is_match) begin
      run_mid     = run_add;
      pending_mid = pending_q;
      hit_mid     = hit_q;
    end else if (is_indel) begin
      run_mid     = run_q;
      pending_mid = pending_q;
      hit_mid     = hit_q;
    end else begin
      run_mid     = '0;
      hit_mid     = hit_q || (pending_q && left_short);
      pending_mid = (item_i.op_code == lgf_pkg::OpN) && !first_q && !end_mate &&
                    ((item_i.op_len >= cfg_i.min_gap) || del_in_range_q) && left_short;
    end

    // End of mate closes the run.
    hit_end = hit_mid || (end_mate && pending_mid && (run_mid <= cfg_i.short_run));
  end

  always_comb begin
    split_contig_d  = split_contig_q;
    split_reverse_d = split_reverse_q;
    split_start_d   = split_start_q;
    split_end_d     = split_end_q;
    is_split_d      = is_split_q;
    skip_d          = skip_q;
    del_in_range_d  = del_in_range_q;
    run_d           = run_q;
    pending_d       = pending_q;
    first_d         = first_q;
    hit_d           = hit_q;
    kept_d          = kept_q;
    res_o           = '0;
    if (step_i) begin
      case (item_i.command)
        lgf_pkg::CMD_SPLIT: begin
          skip_d          = item_i.already_filtered;
          is_split_d      = item_i.three_mate;
          split_contig_d  = item_i.contig;
          split_reverse_d = item_i.reverse_strand;
          split_start_d   = item_i.start_pos;
          split_end_d     = item_i.end_pos;
          del_in_range_d  = (cfg_i.min_gap == '0);
          run_d           = '0;
          pending_d       = 1'b0;
          first_d         = 1'b1;
          hit_d           = 1'b0;
        end
        lgf_pkg::CMD_SUPP: begin
          del_in_range_d = del_ok;
        end
        lgf_pkg::CMD_OP: begin
          run_d     = end_mate ? '0 : run_mid;
          pending_d = end_mate ? 1'b0 : pending_mid;
          first_d   = end_mate;
          hit_d     = hit_end;
          if (item_i.last_of_alignment) begin
            if (!skip_q && !hit_end && (kept_q != '1)) begin
              kept_d = kept_q + lgf_pkg::CountW'(1);
            end
            res_o.valid        = 1'b1;
            res_o.discarded    = hit_end && !skip_q;
            res_o.was_filtered = skip_q;
            res_o.kept_count   = kept_d;
            hit_d              = 1'b0;
          end
        end
        default: begin
          run_d = run_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      split_contig_q  <= '0;
      split_reverse_q <= 1'b0;
      split_start_q   <= '0;
      split_end_q     <= '0;
      is_split_q      <= 1'b0;
      skip_q          <= 1'b0;
      del_in_range_q  <= 1'b0;
      run_q           <= '0;
      pending_q       <= 1'b0;
      first_q         <= 1'b1;
      hit_q           <= 1'b0;
      kept_q          <= '0;
    end else begin
      split_contig_q  <= split_contig_d;
      split_reverse_q <= split_reverse_d;
      split_start_q   <= split_start_d;
      split_end_q     <= split_end_d;
      is_split_q      <= is_split_d;
      skip_q          <= skip_d;
      del_in_range_q  <= del_in_range_d;
      run_q           <= run_d;
      pending_q       <= pending_d;
      first_q         <= first_d;
      hit_q           <= hit_d;
      kept_q          <= kept_d;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/cigar_long_gap_filter.sv
// Top level of the long-gap filter: input register, core update, result register.
// Depends on lgf_pkg, lgf_cfg_regs and lgf_core.
//
//   channel   direction  transfer when                  payload
//   s_axis    in         s_axis_tvalid_i & tready_o     item: tuser command, tlast end of alignment
//   m_axis    out        m_axis_tvalid_o & tready_i     verdict and kept count
//   cfg       in         cfg_valid_i & cfg_ready_o      register index, write data
//
// One item per cycle sustained unless the result side stalls; an item enters the input
// register at its transfer edge; the core update as it leaves loads the result register.
// Reset clears alignment state, the kept count and both pipeline valid flags and
// loads the register reset values.
// A stalled result holds the pipeline; the input register still takes an item
// while the result register is full, and tready drops only when both are occupied.
`timescale 1ns / 1ps
`default_nettype none

module cigar_long_gap_filter (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  // already_filtered[0], three_mate[1], contig[17:2], reverse_strand[18],
  // start_pos[49:19], end_pos[80:50], op_code[84:81], op_len[112:85],
  // last_op[113], zero fill[119:114]
  input  wire logic [119:0] s_axis_tdata_i,
  // command[1:0]
  input  wire logic [1:0]   s_axis_tuser_i,
  input  wire logic         s_axis_tlast_i,
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  // discarded[0], was_filtered[1], kept_count[33:2], zero fill[39:34]
  output logic [39:0]       m_axis_tdata_o,
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic [1:0]   cfg_index_i,
  input  wire logic [31:0]  cfg_data_i
);

  lgf_pkg::item_t in_q, in_d;
  logic           in_valid_q, in_valid_d;
  lgf_pkg::res_t  core_res;
  lgf_pkg::res_t  out_q, out_d;
  logic           out_valid_q, out_valid_d;
  lgf_pkg::cfg_t  cfg;
  logic           advance;
  logic           s_xfer;

  assign cfg_ready_o = 1'b1;

  lgf_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i && cfg_ready_o),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign s_xfer          = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    in_d                   = in_q;
    in_valid_d             = in_valid_q && !advance;
    if (s_xfer) begin
      in_valid_d             = 1'b1;
      in_d.command           = s_axis_tuser_i;
      in_d.already_filtered  = s_axis_tdata_i[0];
      in_d.three_mate        = s_axis_tdata_i[1];
      in_d.contig            = s_axis_tdata_i[17:2];
      in_d.reverse_strand    = s_axis_tdata_i[18];
      in_d.start_pos         = s_axis_tdata_i[49:19];
      in_d.end_pos           = s_axis_tdata_i[80:50];
      in_d.op_code           = s_axis_tdata_i[84:81];
      in_d.op_len            = s_axis_tdata_i[112:85];
      in_d.last_op           = s_axis_tdata_i[113];
      in_d.last_of_alignment = s_axis_tlast_i;
    end
  end

  lgf_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .item_i (in_q),
    .cfg_i  (cfg),
    .res_o  (core_res)
  );

  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    if (advance && core_res.valid) begin
      out_d       = core_res;
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q  <= in_d;
    out_q <= out_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'b000000, out_q.kept_count, out_q.was_filtered, out_q.discarded};

  a_ready_low_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (in_valid_q && out_valid_q && !m_axis_tready_i))
    else $error("input stalled while pipeline can move");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && core_res.valid) |=> out_valid_q)
    else $error("result lost on advance");

  a_verdict_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.discarded && out_q.was_filtered))
    else $error("discarded and was_filtered both set");

endmodule

`default_nettype wire

### bench/tb_top.sv
// Testbench for cigar_long_gap_filter: streams alignments, predicts each verdict and checks it.
// Depends on lgf_pkg and the cigar_long_gap_filter RTL; needs nothing else.
`timescale 1ns / 1ps

module tb_top;

  localparam logic [lgf_pkg::OpW-1:0] OpS            = 4'd4;
  localparam logic [lgf_pkg::OpW-1:0] OpH            = 4'd5;
  localparam logic [lgf_pkg::OpW-1:0] OpFirstUnknown = 4'd9;
  localparam logic [lgf_pkg::OpW-1:0] OpLastUnknown  = 4'd15;
  localparam logic [1:0]     CmdIgnored     = 2'd3;
  localparam logic [27:0]    Max28          = 28'hFFFFFFF;
  localparam int             SettleCycles   = 8;
  localparam int             IdleLimit      = 4000;
  localparam int             PhaseItems     = 130;

  typedef struct packed {
    logic        discarded;
    logic        was_filtered;
    logic [31:0] kept_count;
  } verdict_t;

  class gap_filter_scoreboard;
    bit [27:0] min_gap;
    bit [30:0] max_deletion;
    bit [27:0] short_run;
    bit [15:0] sp_contig;
    bit        sp_rev;
    bit [30:0] sp_start;
    bit [30:0] sp_end;
    bit        split_mode;
    bit        skip_aln;
    bit        del_hit;
    bit [27:0] run_len;
    bit        gap_open;
    bit        first_op;
    bit        hit;
    bit [31:0] kept;
    verdict_t  verdict_q[$];
    int        errors;

    function new();
      min_gap      = lgf_pkg::MinGapRst;
      max_deletion = lgf_pkg::MaxDeletionRst;
      short_run    = lgf_pkg::ShortRunRst;
      sp_contig    = '0;
      sp_rev       = 1'b0;
      sp_start     = '0;
      sp_end       = '0;
      split_mode   = 1'b0;
      skip_aln     = 1'b0;
      del_hit      = 1'b0;
      kept         = '0;
      errors       = 0;
      clear_alignment();
    endfunction

    function void clear_alignment();
      run_len  = '0;
      gap_open = 1'b0;
      first_op = 1'b1;
      hit      = 1'b0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        lgf_pkg::REG_MIN_GAP:      min_gap = val[27:0];
        lgf_pkg::REG_MAX_DELETION: max_deletion = val[30:0];
        lgf_pkg::REG_SHORT_RUN:    short_run = val[27:0];
        default: ;
      endcase
    endfunction

    function bit in_range(longint del);
      longint lo;
      longint hi;
      lo = min_gap;
      hi = max_deletion;
      return del >= lo && del <= hi;
    endfunction

    function void close_run();
      if (gap_open && run_len <= short_run) hit = 1'b1;
      gap_open = 1'b0;
      run_len  = '0;
    endfunction

    function void note_item(lgf_pkg::item_t it);
      longint    del;
      longint    lhs;
      bit        end_mate;
      bit [27:0] left_run;
      bit [28:0] sum;
      verdict_t  v;
      del = 0;
      case (it.command)
        lgf_pkg::CMD_SPLIT: begin
          skip_aln   = it.already_filtered;
          split_mode = it.three_mate;
          sp_contig  = it.contig;
          sp_rev     = it.reverse_strand;
          sp_start   = it.start_pos;
          sp_end     = it.end_pos;
          del_hit    = in_range(0);
          clear_alignment();
        end
        lgf_pkg::CMD_SUPP: begin
          if (split_mode && it.contig == sp_contig && it.reverse_strand == sp_rev) begin
            if (it.reverse_strand) begin
              lhs = it.start_pos;
              del = lhs - longint'(sp_end);
            end else begin
              lhs = sp_start;
              del = lhs - longint'(it.end_pos);
            end
          end
          del_hit = in_range(del);
        end
        lgf_pkg::CMD_OP: begin
          end_mate = it.last_op | it.last_of_alignment;
          if (it.op_code inside {lgf_pkg::OpM, lgf_pkg::OpEq, lgf_pkg::OpX}) begin
            sum     = run_len + it.op_len;
            run_len = sum[28] ? Max28 : sum[27:0];
          end else if (!(it.op_code inside {lgf_pkg::OpI, lgf_pkg::OpD, lgf_pkg::OpP})) begin
            left_run = run_len;
            close_run();
            if (it.op_code == lgf_pkg::OpN && !first_op && !end_mate &&
                (it.op_len >= min_gap || del_hit) && left_run <= short_run)
              gap_open = 1'b1;
          end
          first_op = 1'b0;
          if (end_mate) begin
            close_run();
            first_op = 1'b1;
          end
          if (it.last_of_alignment) begin
            v.discarded    = hit && !skip_aln;
            v.was_filtered = skip_aln;
            if (!skip_aln && !hit && kept != '1) kept++;
            v.kept_count = kept;
            verdict_q.push_back(v);
            clear_alignment();
          end
        end
        default: ;
      endcase
    endfunction

    function void check_verdict(logic disc, logic filt, logic [31:0] count);
      verdict_t exp_v;
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected result discarded %0b was_filtered %0b kept_count %0d",
                 $time, disc, filt, count);
        errors++;
        return;
      end
      exp_v = verdict_q.pop_front();
      if (disc !== exp_v.discarded) begin
        $display("%0t: discarded expected %0b actual %0b", $time, exp_v.discarded, disc);
        errors++;
      end
      if (filt !== exp_v.was_filtered) begin
        $display("%0t: was_filtered expected %0b actual %0b", $time, exp_v.was_filtered, filt);
        errors++;
      end
      if (count !== exp_v.kept_count) begin
        $display("%0t: kept_count expected %0d actual %0d", $time, exp_v.kept_count, count);
        errors++;
      end
    endfunction
  endclass

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_valid = 1'b0;
  logic [119:0] s_data = '0;
  logic [1:0]   s_user = '0;
  logic         s_last = 1'b0;
  logic         m_ready = 1'b0;
  logic         cfg_valid = 1'b0;
  logic [1:0]   cfg_index = '0;
  logic [31:0]  cfg_data = '0;
  logic [15:0]  ready_mask = '1;
  logic [3:0]   ready_phase = '0;

  wire          s_axis_tready_o;
  wire          m_axis_tvalid_o;
  wire  [39:0]  m_axis_tdata_o;
  wire          cfg_ready_o;

  gap_filter_scoreboard sb = new();
  int burst_left = 0;
  int gap_max = 4;
  int sent = 0;
  int idle_cycles = 0;

  cigar_long_gap_filter u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .s_axis_tlast_i  (s_last),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    ready_phase <= ready_phase + 4'd1;
    m_ready     <= ready_mask[ready_phase];
  end

  always @(posedge clk_i) begin : monitor
    lgf_pkg::item_t seen;
    if (rst_ni) begin
      if (s_valid && s_axis_tready_o) begin
        seen.command           = s_user;
        seen.already_filtered  = s_data[0];
        seen.three_mate        = s_data[1];
        seen.contig            = s_data[17:2];
        seen.reverse_strand    = s_data[18];
        seen.start_pos         = s_data[49:19];
        seen.end_pos           = s_data[80:50];
        seen.op_code           = s_data[84:81];
        seen.op_len            = s_data[112:85];
        seen.last_op           = s_data[113];
        seen.last_of_alignment = s_last;
        sb.note_item(seen);
      end
      if (m_axis_tvalid_o && m_ready)
        sb.check_verdict(m_axis_tdata_o[0], m_axis_tdata_o[1], m_axis_tdata_o[33:2]);
      if (cfg_valid && cfg_ready_o) sb.set_reg(cfg_index, cfg_data);
      if ((s_valid && s_axis_tready_o) || (m_axis_tvalid_o && m_ready) ||
          (cfg_valid && cfg_ready_o))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("%0t: no transfer for %0d cycles", $time, IdleLimit);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  function automatic lgf_pkg::item_t rand_item();
    lgf_pkg::item_t it;
    it = $bits(lgf_pkg::item_t)'({$urandom, $urandom, $urandom, $urandom});
    return it;
  endfunction

  function automatic lgf_pkg::item_t mk_split(logic filt, logic split, logic [15:0] contig,
                                              logic rev, logic [30:0] start_p,
                                              logic [30:0] end_p);
    lgf_pkg::item_t it;
    it = rand_item();
    it.command          = lgf_pkg::CMD_SPLIT;
    it.already_filtered = filt;
    it.three_mate       = split;
    it.contig           = contig;
    it.reverse_strand   = rev;
    it.start_pos        = start_p;
    it.end_pos          = end_p;
    return it;
  endfunction

  function automatic lgf_pkg::item_t mk_supp(logic [15:0] contig, logic rev,
                                             logic [30:0] start_p, logic [30:0] end_p);
    lgf_pkg::item_t it;
    it = rand_item();
    it.command        = lgf_pkg::CMD_SUPP;
    it.contig         = contig;
    it.reverse_strand = rev;
    it.start_pos      = start_p;
    it.end_pos        = end_p;
    return it;
  endfunction

  function automatic lgf_pkg::item_t mk_op(logic [3:0] op, logic [27:0] len, logic last,
                                           logic last_all);
    lgf_pkg::item_t it;
    it = rand_item();
    it.command           = lgf_pkg::CMD_OP;
    it.op_code           = op;
    it.op_len            = len;
    it.last_op           = last;
    it.last_of_alignment = last_all;
    return it;
  endfunction

  function automatic logic [27:0] clamp28(longint v);
    if (v < 0) return '0;
    if (v > longint'(Max28)) return Max28;
    return v[27:0];
  endfunction

  function automatic logic [3:0] pick_op();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 30) return lgf_pkg::OpM;
    if (roll < 50) return lgf_pkg::OpN;
    if (roll < 58) begin
      case ($urandom_range(0, 2))
        0: return lgf_pkg::OpI;
        1: return lgf_pkg::OpD;
        default: return lgf_pkg::OpP;
      endcase
    end
    if (roll < 66) return $urandom_range(0, 1) ? lgf_pkg::OpEq : lgf_pkg::OpX;
    if (roll < 74) return $urandom_range(0, 1) ? OpS : OpH;
    if (roll < 78) return 4'($urandom_range(OpFirstUnknown, OpLastUnknown));
    return lgf_pkg::OpM;
  endfunction

  function automatic logic [27:0] pick_len(logic [3:0] op);
    longint base;
    if (op == lgf_pkg::OpN) begin
      base = sb.min_gap;
      case ($urandom_range(0, 7))
        0, 1, 2, 3: return clamp28(base + $urandom_range(0, 2) - 1);
        4: return 28'($urandom_range(0, 50));
        5: return 28'($urandom);
        6: return Max28;
        default: return '0;
      endcase
    end
    base = sb.short_run;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return 28'($urandom_range(0, 20));
      5, 6: return clamp28(base + $urandom_range(0, 2) - 1);
      7: return 28'($urandom);
      8: return '0;
      default: return Max28;
    endcase
  endfunction

  function automatic longint pick_del();
    longint lo;
    longint hi;
    lo = sb.min_gap;
    hi = sb.max_deletion;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return (lo <= hi) ? lo + $urandom_range(0, 32'(hi - lo)) : lo;
      4: return lo - 1;
      5: return lo;
      6: return hi;
      7: return hi + 1;
      8: return -longint'($urandom_range(1, 1000));
      default: return longint'($urandom) - 64'sd2147483648;
    endcase
  endfunction

  task automatic push_item(lgf_pkg::item_t it);
    int gap;
    if (burst_left <= 0) begin
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0) begin
        s_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    s_valid <= 1'b1;
    s_data  <= {6'b0, it.last_op, it.op_len, it.op_code, it.end_pos, it.start_pos,
                it.reverse_strand, it.contig, it.three_mate, it.already_filtered};
    s_user  <= it.command;
    s_last  <= it.last_of_alignment;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    burst_left--;
    if (it.command != CmdIgnored) sent++;
  endtask

  task automatic drain_results();
    s_valid <= 1'b0;
    while (sb.verdict_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    burst_left = 0;
  endtask

  task automatic write_config(logic [31:0] gap_val, logic [31:0] del_val,
                              logic [31:0] run_val);
    cfg_valid <= 1'b1;
    cfg_index <= lgf_pkg::REG_MIN_GAP;
    cfg_data  <= gap_val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_index <= lgf_pkg::REG_MAX_DELETION;
    cfg_data  <= del_val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_index <= lgf_pkg::REG_SHORT_RUN;
    cfg_data  <= run_val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_alignment();
    lgf_pkg::item_t head;
    lgf_pkg::item_t it;
    int     roll;
    int     n_mates;
    int     n_ops;
    longint del;
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      it = rand_item();
      it.command = CmdIgnored;
      push_item(it);
    end
    head = mk_split($urandom_range(0, 9) == 0, $urandom_range(0, 9) < 7,
                    $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 3)),
                    1'($urandom), 31'($urandom), 31'($urandom));
    if (roll >= 6) push_item(head);
    if ($urandom_range(0, 4) != 0) begin
      it = mk_supp(head.contig, head.reverse_strand, 31'($urandom), 31'($urandom));
      if ($urandom_range(0, 3) == 0) it.contig = 16'($urandom_range(0, 3));
      if ($urandom_range(0, 3) == 0) it.reverse_strand = ~it.reverse_strand;
      del = pick_del();
      if (it.reverse_strand) it.start_pos = 31'(longint'(head.end_pos) + del);
      else it.end_pos = 31'(longint'(head.start_pos) - del);
      push_item(it);
    end
    n_mates = $urandom_range(1, 3);
    for (int m = 0; m < n_mates; m++) begin
      n_ops = $urandom_range(1, 7);
      for (int k = 0; k < n_ops; k++) begin
        it = mk_op(pick_op(), '0, k == n_ops - 1, (m == n_mates - 1) && (k == n_ops - 1));
        it.op_len = pick_len(it.op_code);
        if ($urandom_range(0, 29) == 0) it.last_op = ~it.last_op;
        push_item(it);
      end
    end
  endtask

  initial begin : stimulus
    lgf_pkg::item_t it;
    int    target;
    repeat (10) @(posedge clk_i);
    rst_ni  <= 1'b1;
    @(posedge clk_i);

    // long-deletion split read with short flanks around a short skip
    push_item(mk_split(1'b0, 1'b1, 16'hFFFF, 1'b1, 31'h7FFFFFFF, 31'd100));
    push_item(mk_supp(16'hFFFF, 1'b1, 31'd1000100, 31'h7FFFFFFF));
    push_item(mk_op(lgf_pkg::OpM, 28'd10, 1'b0, 1'b0));
    push_item(mk_op(lgf_pkg::OpN, 28'd5, 1'b0, 1'b0));
    push_item(mk_op(lgf_pkg::OpM, 28'd10, 1'b1, 1'b0));
    push_item(mk_op(lgf_pkg::OpM, Max28, 1'b1, 1'b1));
    // already filtered upstream
    push_item(mk_split(1'b1, 1'b0, '0, 1'b0, '0, '0));
    push_item(mk_op(lgf_pkg::OpM, 28'd5, 1'b0, 1'b0));
    push_item(mk_op(lgf_pkg::OpN, Max28, 1'b0, 1'b0));
    push_item(mk_op(lgf_pkg::OpM, 28'd5, 1'b1, 1'b1));
    // no header; every op kind, saturating run, end of alignment without end of mate
    push_item(mk_op(lgf_pkg::OpN, 28'd800000, 1'b0, 1'b0));
    push_item(mk_op(OpS, '0, 1'b0, 1'b0));
    push_item(mk_op(lgf_pkg::OpI, 28'd7, 1'b0, 1'b0));
    push_item(mk_op(lgf_pkg::OpD, 28'd7, 1'b0, 1'b0));
    push_item(mk_op(lgf_pkg::OpP, 28'd7, 1'b0, 1'b0));
    push_item(mk_op(lgf_pkg::OpEq, 28'd3, 1'b0, 1'b0));
    push_item(mk_op(lgf_pkg::OpX, Max28, 1'b0, 1'b0));
    push_item(mk_op(lgf_pkg::OpX, 28'd1, 1'b0, 1'b0));
    push_item(mk_op(OpH, '0, 1'b0, 1'b0));
    push_item(mk_op(OpLastUnknown, 28'd9, 1'b0, 1'b0));
    push_item(mk_op(lgf_pkg::OpM, 28'd2, 1'b0, 1'b1));
    it = '1;
    it.command = CmdIgnored;
    push_item(it);
    // supplementary record without split read
    push_item(mk_split(1'b0, 1'b0, 16'd5, 1'b0, 31'd2000000, 31'd10));
    push_item(mk_supp(16'd5, 1'b0, '0, 31'd1000000));
    push_item(mk_op(lgf_pkg::OpM, 28'd3, 1'b0, 1'b0));
    push_item(mk_op(lgf_pkg::OpN, 28'd10, 1'b0, 1'b0));
    push_item(mk_op(lgf_pkg::OpM, 28'd3, 1'b1, 1'b1));

    for (int ph = 0; ph < 6; ph++) begin
      drain_results();
      case (ph)
        0: write_config('0, '0, '0);
        1: write_config('1, '1, '1);
        2: write_config($urandom_range(0, 300), $urandom_range(300, 900),
                        $urandom_range(0, 40));
        3: write_config({4'($urandom), 28'(lgf_pkg::MinGapRst)},
                        {1'($urandom), lgf_pkg::MaxDeletionRst},
                        {4'($urandom), lgf_pkg::ShortRunRst});
        4: write_config({4'h0, Max28}, '0, '0);
        default: write_config($urandom_range(0, 2000000), $urandom, $urandom_range(0, 100));
      endcase
      ready_mask <= (ph % 3 == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
      gap_max = (ph == 3) ? 0 : $urandom_range(2, 8);
      target = sent + PhaseItems;
      while (sent < target) begin
        send_alignment();
        if ($urandom_range(0, 39) == 0) drain_results();
      end
    end

    drain_results();
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0 && sb.verdict_q.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
